>>> src/command_frame_byte_parser_top_assert.svh
// Assertion macros for the command frame byte parser.
`ifndef COMMAND_FRAME_BYTE_PARSER_TOP_ASSERT_SVH
`define COMMAND_FRAME_BYTE_PARSER_TOP_ASSERT_SVH

`ifndef ASSERT_OFF
`define CFBP_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("cfbp assertion failed");
`define CFBP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("cfbp assertion failed");
`else
`define CFBP_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define CFBP_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

>>> src/cfbp_pkg.sv
`default_nettype none

package cfbp_pkg;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

   typedef enum logic [2:0] {
      EV_HEADER = 3'd0,
      EV_NAME   = 3'd1,
      EV_INT    = 3'd2,
      EV_CHAR   = 3'd3,
      EV_EMPTY  = 3'd4,
      EV_BAD    = 3'd5
   } event_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       is_type_int;
      logic       is_type_str;
   } queue_item_type;

endpackage

`default_nettype wire

>>> src/cfbp_front.sv
`default_nettype none

module cfbp_front
   import cfbp_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           push_valid,
   output logic                push_ready,
   input  wire logic [7:0]     push_byte,
   output logic                pop_valid,
   input  wire logic           pop_ready,
   output queue_item_type      pop_item
);

   queue_item_type            entry_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]       wr_ptr_ff;
   logic [QUEUE_AW-1:0]       rd_ptr_ff;
   logic [QUEUE_AW:0]         count_ff;
   logic                      push;
   logic                      pop;
   queue_item_type            item_in;

   assign push_ready = (count_ff != (QUEUE_AW+1)'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_item   = entry_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   // type byte classes resolved up front
   always_comb begin
      item_in.data_byte   = push_byte;
      item_in.is_type_int = (push_byte == 8'd0);
      item_in.is_type_str = (push_byte == 8'd1);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= item_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + QUEUE_AW'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + QUEUE_AW'(1);
         end
         case ({push, pop})
            2'b10:   count_ff <= count_ff + (QUEUE_AW+1)'(1);
            2'b01:   count_ff <= count_ff - (QUEUE_AW+1)'(1);
            default: count_ff <= count_ff;
         endcase
      end
   end

endmodule

`default_nettype wire

>>> src/cfbp_back.sv
`default_nettype none

module cfbp_back
   import cfbp_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           item_valid,
   output logic                item_ready,
   input  wire queue_item_type item,
   output logic                rsp_valid,
   input  wire logic           rsp_ready,
   output event_type           rsp_event,
   output logic [31:0]         rsp_value,
   output logic [31:0]         rsp_arg_number,
   output logic                rsp_string_end,
   output logic                rsp_command_end
);

   typedef enum logic [2:0] {
      PH_NAME_LEN = 3'd0,
      PH_NAME     = 3'd1,
      PH_ARGC     = 3'd2,
      PH_TYPE     = 3'd3,
      PH_INT      = 3'd4,
      PH_STR_LEN  = 3'd5,
      PH_STR      = 3'd6
   } phase_type;

   phase_type    phase_ff, phase_in;
   logic [1:0]   byte_position_ff, byte_position_in;
   logic [31:0]  bytes_left_ff, bytes_left_in;
   logic [31:0]  args_left_ff, args_left_in;
   logic [31:0]  arg_counter_ff, arg_counter_in;
   logic [31:0]  word_gather_ff, word_gather_in;

   logic         rsp_valid_ff;
   event_type    event_ff, event_in;
   logic [31:0]  value_ff, value_in;
   logic [31:0]  arg_number_ff, arg_number_in;
   logic         string_end_ff, string_end_in;
   logic         command_end_ff, command_end_in;

   logic [31:0]  gathered;
   logic         word_done;
   logic [31:0]  bytes_dec;
   logic [31:0]  args_dec;
   logic         advance;

   assign item_ready      = !rsp_valid_ff || rsp_ready;
   assign advance         = item_valid && item_ready;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_event       = event_ff;
   assign rsp_value       = value_ff;
   assign rsp_arg_number  = arg_number_ff;
   assign rsp_string_end  = string_end_ff;
   assign rsp_command_end = command_end_ff;

   assign gathered  = (byte_position_ff == 2'd0) ? {24'd0, item.data_byte}
                    : (word_gather_ff | ({24'd0, item.data_byte} << {byte_position_ff, 3'b000}));
   assign word_done = (byte_position_ff == 2'd3);
   assign bytes_dec = bytes_left_ff - 32'd1;
   assign args_dec  = args_left_ff - 32'd1;

   always_comb begin
      phase_in         = phase_ff;
      byte_position_in = byte_position_ff;
      bytes_left_in    = bytes_left_ff;
      args_left_in     = args_left_ff;
      arg_counter_in   = arg_counter_ff;
      word_gather_in   = word_gather_ff;
      event_in         = EV_HEADER;
      value_in         = 32'd0;
      arg_number_in    = arg_counter_ff;
      string_end_in    = 1'b0;
      command_end_in   = 1'b0;

      unique case (phase_ff)
         PH_NAME: begin
            event_in      = EV_NAME;
            value_in      = {24'd0, item.data_byte};
            bytes_left_in = bytes_dec;
            if (bytes_dec == 32'd0) begin
               string_end_in    = 1'b1;
               phase_in         = PH_ARGC;
               byte_position_in = 2'd0;
            end
         end
         PH_ARGC: begin
            word_gather_in   = gathered;
            byte_position_in = byte_position_ff + 2'd1;
            if (word_done) begin
               args_left_in   = gathered;
               arg_counter_in = 32'd0;
               arg_number_in  = 32'd0;
               if (gathered == 32'd0) begin
                  command_end_in = 1'b1;
                  phase_in       = PH_NAME_LEN;
               end else begin
                  phase_in = PH_TYPE;
               end
            end
         end
         PH_TYPE: begin
            byte_position_in = 2'd0;
            if (item.is_type_int) begin
               phase_in = PH_INT;
            end else if (item.is_type_str) begin
               phase_in = PH_STR_LEN;
            end else begin
               event_in       = EV_BAD;
               arg_counter_in = 32'd0;
               args_left_in   = 32'd0;
               phase_in       = PH_NAME_LEN;
            end
         end
         PH_INT: begin
            word_gather_in   = gathered;
            byte_position_in = byte_position_ff + 2'd1;
            if (word_done) begin
               event_in     = EV_INT;
               value_in     = gathered;
               args_left_in = args_dec;
               if (args_dec == 32'd0) begin
                  arg_counter_in = 32'd0;
                  phase_in       = PH_NAME_LEN;
                  command_end_in = 1'b1;
               end else begin
                  arg_counter_in = arg_counter_ff + 32'd1;
                  phase_in       = PH_TYPE;
               end
            end
         end
         PH_STR_LEN: begin
            word_gather_in   = gathered;
            byte_position_in = byte_position_ff + 2'd1;
            if (word_done) begin
               bytes_left_in = gathered;
               if (gathered == 32'd0) begin
                  event_in      = EV_EMPTY;
                  string_end_in = 1'b1;
                  args_left_in  = args_dec;
                  if (args_dec == 32'd0) begin
                     arg_counter_in = 32'd0;
                     phase_in       = PH_NAME_LEN;
                     command_end_in = 1'b1;
                  end else begin
                     arg_counter_in = arg_counter_ff + 32'd1;
                     phase_in       = PH_TYPE;
                  end
               end else begin
                  phase_in = PH_STR;
               end
            end
         end
         PH_STR: begin
            event_in      = EV_CHAR;
            value_in      = {24'd0, item.data_byte};
            bytes_left_in = bytes_dec;
            if (bytes_dec == 32'd0) begin
               string_end_in    = 1'b1;
               byte_position_in = 2'd0;
               args_left_in     = args_dec;
               if (args_dec == 32'd0) begin
                  arg_counter_in = 32'd0;
                  phase_in       = PH_NAME_LEN;
                  command_end_in = 1'b1;
               end else begin
                  arg_counter_in = arg_counter_ff + 32'd1;
                  phase_in       = PH_TYPE;
               end
            end
         end
         default: begin
            // name length, also the unused code
            if (byte_position_ff == 2'd0) begin
               arg_counter_in = 32'd0;
            end
            arg_number_in    = 32'd0;
            phase_in         = PH_NAME_LEN;
            word_gather_in   = gathered;
            byte_position_in = byte_position_ff + 2'd1;
            if (word_done) begin
               bytes_left_in = gathered;
               if (gathered == 32'd0) begin
                  event_in      = EV_EMPTY;
                  string_end_in = 1'b1;
                  phase_in      = PH_ARGC;
               end else begin
                  phase_in = PH_NAME;
               end
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= PH_NAME_LEN;
         byte_position_ff <= 2'd0;
         bytes_left_ff    <= 32'd0;
         args_left_ff     <= 32'd0;
         arg_counter_ff   <= 32'd0;
         word_gather_ff   <= 32'd0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         if (item_ready) begin
            rsp_valid_ff <= item_valid;
         end
         if (advance) begin
            phase_ff         <= phase_in;
            byte_position_ff <= byte_position_in;
            bytes_left_ff    <= bytes_left_in;
            args_left_ff     <= args_left_in;
            arg_counter_ff   <= arg_counter_in;
            word_gather_ff   <= word_gather_in;
            event_ff         <= event_in;
            value_ff         <= value_in;
            arg_number_ff    <= arg_number_in;
            string_end_ff    <= string_end_in;
            command_end_ff   <= command_end_in;
         end
      end
   end

endmodule

`default_nettype wire

>>> src/command_frame_byte_parser_top.sv
// Command frame byte parser.
// req_ carries one raw stream byte per item; rsp_ returns exactly one result
// item per byte, in order: tuser holds the event kind and the string end flag,
// tdata the character or integer value and the argument index, and tlast
// marks the last byte of a whole command.
// A byte accepted on req_ is written into the queue, then registered into
// the result stage before it shows on rsp_. One byte per cycle is sustained:
// a 4-entry queue between the input side and the parser, and a registered
// result stage, let a new byte enter every cycle while results are being taken.
// The parser state advances by one byte per cycle; the per-byte update
// (a 32-bit decrement and compare) sets the cycle time.
// When the receiver holds rsp_tready low, the result stage holds its item,
// the parser stops, and the queue takes up to four more bytes before
// req_tready falls.
// Reset (synchronous, active high) empties the queue, drops rsp_tvalid and
// puts the parser back to waiting for a name length.
// After a bad type byte the parser waits for a new command header.
`default_nettype none

`include "command_frame_byte_parser_top_assert.svh"

module command_frame_byte_parser_top
   import cfbp_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] data_byte
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [63:0]      rsp_tdata,   // [31:0] value, [63:32] arg_number
   output logic [3:0]       rsp_tuser,   // [2:0] event_res, [3] string_end
   output logic             rsp_tlast    // command_end
);

   logic            q_valid;
   logic            q_ready;
   queue_item_type  q_item;
   event_type       rsp_event;
   logic [31:0]     rsp_value;
   logic [31:0]     rsp_arg_number;
   logic            rsp_string_end;

   cfbp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .push_valid (req_tvalid),
      .push_ready (req_tready),
      .push_byte  (req_tdata),
      .pop_valid  (q_valid),
      .pop_ready  (q_ready),
      .pop_item   (q_item)
   );

   cfbp_back u_back (
      .clock           (clock),
      .reset           (reset),
      .item_valid      (q_valid),
      .item_ready      (q_ready),
      .item            (q_item),
      .rsp_valid       (rsp_tvalid),
      .rsp_ready       (rsp_tready),
      .rsp_event       (rsp_event),
      .rsp_value       (rsp_value),
      .rsp_arg_number  (rsp_arg_number),
      .rsp_string_end  (rsp_string_end),
      .rsp_command_end (rsp_tlast)
   );

   assign rsp_tdata = {rsp_arg_number, rsp_value};
   assign rsp_tuser = {rsp_string_end, rsp_event};

   `CFBP_ASSERT_NEXT(a_pop_gives_rsp, clock, reset, q_valid && q_ready, rsp_tvalid)
   `CFBP_ASSERT_IMPLY(a_end_kind, clock, reset, rsp_tvalid && rsp_tlast,
      (rsp_event != EV_BAD) && (rsp_event != EV_NAME))
   `CFBP_ASSERT_IMPLY(a_str_end_kind, clock, reset, rsp_tvalid && rsp_string_end,
      (rsp_event == EV_NAME) || (rsp_event == EV_CHAR) || (rsp_event == EV_EMPTY))
   `CFBP_ASSERT_IMPLY(a_no_value, clock, reset,
      rsp_tvalid && ((rsp_event == EV_HEADER) || (rsp_event == EV_BAD)),
      rsp_value == 32'd0)

endmodule

`default_nettype wire
